### sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, muted while reset is high
`define NPT_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the block clock and reset
`define NPT_ASSERT(label, prop, msg) `NPT_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

### sv/npt_pkg.sv
package npt_pkg;

   localparam int CHAR_W   = 8;
   localparam int MICROS_W = 20;

   typedef logic [CHAR_W-1:0] char_type;

   // Characters of the grammar
   localparam char_type CH_N     = 8'h6E;
   localparam char_type CH_P     = 8'h70;
   localparam char_type CH_T     = 8'h74;
   localparam char_type CH_COLON = 8'h3A;
   localparam char_type CH_COMMA = 8'h2C;
   localparam char_type CH_DOT   = 8'h2E;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;

   localparam logic [2:0] PREFIX_LEN = 3'd4;

   // Expected character at each position of the "npt:" prefix
   function automatic char_type prefix_char(input logic [1:0] idx);
      char_type ch;
      unique case (idx)
         2'd0: ch = CH_N;
         2'd1: ch = CH_P;
         2'd2: ch = CH_T;
         2'd3: ch = CH_COLON;
      endcase
      return ch;
   endfunction

endpackage

### sv/npt_if.sv
// Character request channel
interface npt_req_if;
   import npt_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_code;
   logic     last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// Parsed range result channel
interface npt_rsp_if #(
   parameter int SECONDS_WIDTH = 32
);
   import npt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     range_valid;
   logic [SECONDS_WIDTH-1:0] start_seconds;
   logic [MICROS_W-1:0]      start_micros;
   logic                     end_present;
   logic [SECONDS_WIDTH-1:0] end_seconds;
   logic [MICROS_W-1:0]      end_micros;

   modport source (output valid, output range_valid, output start_seconds,
                   output start_micros, output end_present, output end_seconds,
                   output end_micros, input ready);
   modport sink   (input valid, input range_valid, input start_seconds,
                   input start_micros, input end_present, input end_seconds,
                   input end_micros, output ready);
endinterface

### sv/npt_time_range_parser.sv
// NPT time range parser. Characters of a media-fragment time value arrive one per request,
// at a sustained rate of one character per clock cycle unless a last character waits for
// a full closing stage; the single update of the parse state per character (one constant
// multiply by 10 or 60 with a saturating add) sets that rate. The request that carries
// last_char produces exactly one result, which goes through the character register, closing
// stage, range-compare stage and result register to the response channel; other requests
// produce nothing. The parse state returns to the start of a string right after each last
// character, so the next string may follow in the next cycle. Characters keep flowing while
// a result waits to be taken, until the two finishing stages behind it are also full.
`include "assert_macros.svh"

module npt_time_range_parser #(
   parameter int FRAC_DIGITS   = 6,
   parameter int SECONDS_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   npt_req_if.sink   req_chan,
   npt_rsp_if.source rsp_chan
);
   import npt_pkg::*;

   localparam int SW1     = SECONDS_WIDTH + 1;
   localparam int FRAC_W  = $clog2(10 ** FRAC_DIGITS);
   localparam int FCNT_W  = $clog2(FRAC_DIGITS + 1);
   localparam logic [FRAC_W-1:0] FRAC_LIMIT = FRAC_W'(10 ** FRAC_DIGITS);
   localparam logic [FCNT_W-1:0] FRAC_MAXCNT = FCNT_W'(FRAC_DIGITS);
   localparam logic [SW1-1:0]    SAT_VALUE = {1'b1, {SECONDS_WIDTH{1'b0}}};

   // Position in the grammar (low four bits of the phase; bit four marks the end time)
   localparam logic [3:0] PH_BEGIN    = 4'd0;
   localparam logic [3:0] PH_PREFIX   = 4'd1;
   localparam logic [3:0] PH_LEAD     = 4'd2;
   localparam logic [3:0] PH_F1       = 4'd3;
   localparam logic [3:0] PH_FRAC     = 4'd4;
   localparam logic [3:0] PH_C2       = 4'd5;
   localparam logic [3:0] PH_F2       = 4'd6;
   localparam logic [3:0] PH_C2H      = 4'd7;
   localparam logic [3:0] PH_F2H      = 4'd8;
   localparam logic [3:0] PH_C3       = 4'd9;
   localparam logic [3:0] PH_F3       = 4'd10;
   localparam logic [3:0] PH_ENDFIRST = 4'd11;

   // Weight of each fraction digit position, most significant first
   function automatic logic [FRAC_DIGITS*FRAC_W-1:0] weight_table();
      logic [FRAC_DIGITS*FRAC_W-1:0] t;
      longint                        p;
      t = '0;
      p = 1;
      for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
         t[i*FRAC_W +: FRAC_W] = FRAC_W'(p);
         p = p * 10;
      end
      return t;
   endfunction

   localparam logic [FRAC_DIGITS*FRAC_W-1:0] WEIGHTS = weight_table();

   // Character register
   logic     in_vld_ff;
   char_type in_char_ff;
   logic     in_last_ff;

   // Parse state
   logic [4:0]               phase_ff, phase_in;
   logic [2:0]               pcnt_ff, pcnt_in;
   logic [SW1-1:0]           field_ff, field_in;
   logic [1:0]               fcnt_ff, fcnt_in;
   logic [SW1-1:0]           base_ff, base_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic [FCNT_W-1:0]        frcnt_ff, frcnt_in;
   logic [SECONDS_WIDTH-1:0] hsec_ff, hsec_in;
   logic [FRAC_W-1:0]        hfrac_ff, hfrac_in;
   logic                     err_ff, err_in;

   // Closing stage
   logic                     f1_vld_ff;
   logic [4:0]               f1_phase_ff;
   logic [1:0]               f1_fcnt_ff;
   logic [SW1-1:0]           f1_field_ff;
   logic [SW1-1:0]           f1_base_ff;
   logic [FRAC_W-1:0]        f1_frac_ff;
   logic [SECONDS_WIDTH-1:0] f1_hsec_ff;
   logic [FRAC_W-1:0]        f1_hfrac_ff;
   logic                     f1_err_ff;

   // Range-compare stage
   logic                     f2_vld_ff;
   logic                     f2_err_ff, f2_err_in;
   logic                     f2_slot_ff;
   logic [SECONDS_WIDTH-1:0] f2_sec_ff, f2_sec_in;
   logic [FRAC_W-1:0]        f2_frac_ff, f2_frac_in;
   logic [SECONDS_WIDTH-1:0] f2_hsec_ff;
   logic [FRAC_W-1:0]        f2_hfrac_ff;

   // Result register
   logic                     rsp_vld_ff;
   logic                     range_valid_ff, range_valid_in;
   logic [SECONDS_WIDTH-1:0] start_seconds_ff, start_seconds_in;
   logic [MICROS_W-1:0]      start_micros_ff, start_micros_in;
   logic                     end_present_ff, end_present_in;
   logic [SECONDS_WIDTH-1:0] end_seconds_ff, end_seconds_in;
   logic [MICROS_W-1:0]      end_micros_ff, end_micros_in;

   logic in_go, f1_go, f2_go, f1_free;

   // Stage flow: a stage moves on when the one after it is empty or moving
   assign f2_go   = f2_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign f1_go   = f1_vld_ff && (!f2_vld_ff || f2_go);
   assign f1_free = !f1_vld_ff || f1_go;
   assign in_go   = in_vld_ff && (!in_last_ff || f1_free);
   assign req_chan.ready = !in_vld_ff || in_go;

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_char_ff <= req_chan.char_code;
         in_last_ff <= req_chan.last_char;
      end
   end

   // Character decode and shared arithmetic
   logic                    is_dig, is_term;
   logic [3:0]              dval;
   logic [3:0]              ph_base;
   logic                    ph_slot;
   logic [SW1+3:0]          f10;
   logic [SW1-1:0]          field_sat;
   logic [SW1:0]            src60;
   logic [SW1+6:0]          p60;
   logic [SW1-1:0]          base60_sat;
   logic                    whole_ovf;
   logic [FRAC_W-1:0]       weight;
   logic [FRAC_W+3:0]       frac_prod;
   logic [1:0]              fcnt_inc;
   logic                    close_req, comma_req;

   assign is_dig  = (in_char_ff >= CH_ZERO) && (in_char_ff <= CH_NINE);
   assign is_term = (in_char_ff == CH_COMMA) || (in_char_ff == CH_DOT);
   assign dval    = is_dig ? in_char_ff[3:0] : 4'd0;
   assign ph_base = phase_ff[3:0];
   assign ph_slot = phase_ff[4];

   // Append a decimal digit, saturating just above the largest whole-second value
   assign f10 = ({3'b000, field_ff} << 3) + ({3'b000, field_ff} << 1) + (SW1+4)'(dval);
   assign field_sat = (|f10[SW1+3:SECONDS_WIDTH]) ? SAT_VALUE : f10[SW1-1:0];

   // Running base plus current group: the whole time, or the value to scale at a colon
   assign src60     = {1'b0, base_ff} + {1'b0, field_ff};
   assign whole_ovf = |src60[SW1:SECONDS_WIDTH];
   assign p60       = ({6'b000000, src60} << 6) - ({6'b000000, src60} << 2);
   assign base60_sat = (|p60[SW1+6:SECONDS_WIDTH]) ? SAT_VALUE : p60[SW1-1:0];

   assign fcnt_inc = (fcnt_ff == 2'd3) ? 2'd3 : fcnt_ff + 2'd1;

   // Pick the weight of the next fraction digit
   always_comb begin
      weight = '0;
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         if (frcnt_ff == FCNT_W'(i)) begin
            weight = WEIGHTS[i*FRAC_W +: FRAC_W];
         end
      end
   end

   assign frac_prod = {4'b0000, weight} * {{FRAC_W{1'b0}}, dval};

   // Advance the parse state by one character
   always_comb begin
      phase_in  = phase_ff;
      pcnt_in   = pcnt_ff;
      field_in  = field_ff;
      fcnt_in   = fcnt_ff;
      base_in   = base_ff;
      frac_in   = frac_ff;
      frcnt_in  = frcnt_ff;
      hsec_in   = hsec_ff;
      hfrac_in  = hfrac_ff;
      err_in    = err_ff;
      close_req = 1'b0;
      comma_req = 1'b0;

      if (!err_ff) begin
         unique case (ph_base)
            PH_BEGIN, PH_LEAD: begin
               if (ph_base == PH_BEGIN && in_char_ff == CH_N) begin
                  pcnt_in  = 3'd1;
                  phase_in = {1'b0, PH_PREFIX};
               end else if (in_char_ff == CH_COMMA) begin
                  hsec_in  = '0;
                  hfrac_in = '0;
                  phase_in = {1'b0, PH_ENDFIRST};
               end else if (is_dig) begin
                  field_in = SW1'(dval);
                  fcnt_in  = 2'd1;
                  phase_in = {1'b0, PH_F1};
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_PREFIX: begin
               if (pcnt_ff != PREFIX_LEN && in_char_ff == prefix_char(pcnt_ff[1:0])) begin
                  pcnt_in = pcnt_ff + 3'd1;
                  if (pcnt_ff + 3'd1 == PREFIX_LEN) begin
                     phase_in = {1'b0, PH_LEAD};
                  end
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_F1: begin
               if (is_dig) begin
                  field_in = field_sat;
                  fcnt_in  = fcnt_inc;
               end else if (is_term) begin
                  close_req = 1'b1;
               end else if (in_char_ff == CH_COLON && fcnt_ff >= 2'd2) begin
                  base_in  = base60_sat;
                  phase_in = {ph_slot, (fcnt_ff > 2'd2) ? PH_C2H : PH_C2};
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_FRAC: begin
               if (is_dig) begin
                  if (frcnt_ff < FRAC_MAXCNT) begin
                     frac_in  = frac_ff + frac_prod[FRAC_W-1:0];
                     frcnt_in = frcnt_ff + FCNT_W'(1);
                  end
               end else if (in_char_ff == CH_COMMA) begin
                  comma_req = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_C2, PH_C2H, PH_C3: begin
               if (is_dig) begin
                  field_in = SW1'(dval);
                  fcnt_in  = 2'd1;
                  phase_in = {ph_slot, ph_base + 4'd1};
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_F2, PH_F2H, PH_F3: begin
               if (is_dig) begin
                  if (fcnt_ff >= 2'd2) begin
                     err_in = 1'b1;
                  end else begin
                     field_in = field_sat;
                     fcnt_in  = fcnt_inc;
                  end
               end else if (fcnt_ff != 2'd2) begin
                  err_in = 1'b1;
               end else if (in_char_ff == CH_COLON && ph_base != PH_F3) begin
                  base_in  = base60_sat;
                  phase_in = {ph_slot, PH_C3};
               end else if (is_term && ph_base != PH_F2H) begin
                  close_req = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_ENDFIRST: begin
               if (is_dig) begin
                  field_in = SW1'(dval);
                  fcnt_in  = 2'd1;
                  phase_in = {1'b1, PH_F1};
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase

         // Close a whole time on a dot or comma
         if (close_req) begin
            if (whole_ovf) begin
               err_in = 1'b1;
            end else begin
               field_in = src60[SW1-1:0];
               base_in  = '0;
               frac_in  = '0;
               frcnt_in = '0;
               if (in_char_ff == CH_DOT) begin
                  phase_in = {ph_slot, PH_FRAC};
               end else if (ph_slot) begin
                  err_in = 1'b1;
               end else begin
                  hsec_in  = src60[SECONDS_WIDTH-1:0];
                  hfrac_in = '0;
                  phase_in = {1'b0, PH_ENDFIRST};
               end
            end
         end

         // Store the start time after its fraction
         if (comma_req) begin
            if (ph_slot) begin
               err_in = 1'b1;
            end else begin
               hsec_in  = field_ff[SECONDS_WIDTH-1:0];
               hfrac_in = frac_ff;
               phase_in = {1'b0, PH_ENDFIRST};
            end
         end
      end
   end

   // Parse state registers: back to the start of a string after each last character
   always_ff @(posedge clock) begin
      if (reset || (in_go && in_last_ff)) begin
         phase_ff <= {1'b0, PH_BEGIN};
         pcnt_ff  <= '0;
         field_ff <= '0;
         fcnt_ff  <= '0;
         base_ff  <= '0;
         frac_ff  <= '0;
         frcnt_ff <= '0;
         hsec_ff  <= '0;
         hfrac_ff <= '0;
         err_ff   <= 1'b0;
      end else if (in_go) begin
         phase_ff <= phase_in;
         pcnt_ff  <= pcnt_in;
         field_ff <= field_in;
         fcnt_ff  <= fcnt_in;
         base_ff  <= base_in;
         frac_ff  <= frac_in;
         frcnt_ff <= frcnt_in;
         hsec_ff  <= hsec_in;
         hfrac_ff <= hfrac_in;
         err_ff   <= err_in;
      end
   end

   // Capture the final parse state of a string
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (f1_free) begin
         f1_vld_ff <= in_go && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_free && in_go && in_last_ff) begin
         f1_phase_ff <= phase_in;
         f1_fcnt_ff  <= fcnt_in;
         f1_field_ff <= field_in;
         f1_base_ff  <= base_in;
         f1_frac_ff  <= frac_in;
         f1_hsec_ff  <= hsec_in;
         f1_hfrac_ff <= hfrac_in;
         f1_err_ff   <= err_in;
      end
   end

   // Close the last time of the string
   logic [3:0]   f1_base_ph;
   logic [SW1:0] f1_whole;
   logic         f1_closing;

   assign f1_base_ph = f1_phase_ff[3:0];
   assign f1_whole   = {1'b0, f1_base_ff} + {1'b0, f1_field_ff};
   assign f1_closing = (f1_base_ph == PH_F1) ||
                       ((f1_base_ph == PH_F2 || f1_base_ph == PH_F3) && f1_fcnt_ff == 2'd2);

   always_comb begin
      f2_err_in  = f1_err_ff ||
                   (!f1_closing && f1_base_ph != PH_FRAC) ||
                   (f1_closing && (|f1_whole[SW1:SECONDS_WIDTH]));
      f2_sec_in  = f1_closing ? f1_whole[SECONDS_WIDTH-1:0] : f1_field_ff[SECONDS_WIDTH-1:0];
      f2_frac_in = f1_closing ? '0 : f1_frac_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_vld_ff <= 1'b0;
      end else if (!f2_vld_ff || f2_go) begin
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_go) begin
         f2_err_ff   <= f2_err_in;
         f2_slot_ff  <= f1_phase_ff[4];
         f2_sec_ff   <= f2_sec_in;
         f2_frac_ff  <= f2_frac_in;
         f2_hsec_ff  <= f1_hsec_ff;
         f2_hfrac_ff <= f1_hfrac_ff;
      end
   end

   // Check start before end and form the result
   logic                        f2_ok, f2_before;
   logic [FRAC_W+MICROS_W-1:0]  st_frac_ext, en_frac_ext;

   assign f2_before   = {f2_hsec_ff, f2_hfrac_ff} < {f2_sec_ff, f2_frac_ff};
   assign f2_ok       = !f2_err_ff && (!f2_slot_ff || f2_before);
   assign st_frac_ext = {{MICROS_W{1'b0}}, (f2_slot_ff ? f2_hfrac_ff : f2_frac_ff)};
   assign en_frac_ext = {{MICROS_W{1'b0}}, f2_frac_ff};

   always_comb begin
      range_valid_in   = f2_ok;
      start_seconds_in = '0;
      start_micros_in  = '0;
      end_present_in   = 1'b0;
      end_seconds_in   = '0;
      end_micros_in    = '0;
      if (f2_ok) begin
         start_seconds_in = f2_slot_ff ? f2_hsec_ff : f2_sec_ff;
         start_micros_in  = st_frac_ext[MICROS_W-1:0];
         if (f2_slot_ff) begin
            end_present_in = 1'b1;
            end_seconds_in = f2_sec_ff;
            end_micros_in  = en_frac_ext[MICROS_W-1:0];
         end
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (f2_go) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (f2_go) begin
         range_valid_ff   <= range_valid_in;
         start_seconds_ff <= start_seconds_in;
         start_micros_ff  <= start_micros_in;
         end_present_ff   <= end_present_in;
         end_seconds_ff   <= end_seconds_in;
         end_micros_ff    <= end_micros_in;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.range_valid   = range_valid_ff;
   assign rsp_chan.start_seconds = start_seconds_ff;
   assign rsp_chan.start_micros  = start_micros_ff;
   assign rsp_chan.end_present   = end_present_ff;
   assign rsp_chan.end_seconds   = end_seconds_ff;
   assign rsp_chan.end_micros    = end_micros_ff;

   // Checks
   `NPT_ASSERT(a_invalid_is_zero, (rsp_vld_ff && !range_valid_ff) |-> (start_seconds_ff == '0 && start_micros_ff == '0 && !end_present_ff && end_seconds_ff == '0 && end_micros_ff == '0), "rejected range carries nonzero fields")
   `NPT_ASSERT(a_end_needs_valid, (rsp_vld_ff && end_present_ff) |-> range_valid_ff, "end time reported on a rejected range")
   `NPT_ASSERT(a_last_restarts, (in_go && in_last_ff) |=> (phase_ff == {1'b0, PH_BEGIN} && !err_ff && f1_vld_ff), "last character did not restart the parser")
   `NPT_ASSERT(a_frac_bound, (frac_ff < FRAC_LIMIT && hfrac_ff < FRAC_LIMIT), "fraction exceeds its decimal range")

endmodule

### tb/tb_npt_time_range_parser.sv
module tb_npt_time_range_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import npt_pkg::*;

   localparam int SEC_W        = 32;
   localparam int FRAC_KEEP    = 6;
   localparam int RANDOM_ITEMS = 1550;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_MAX   = 10;

   localparam logic [63:0] SEC_LIMIT = (64'd1 << SEC_W) - 64'd1;

   // Position in the grammar; the end-time flag is held apart
   typedef enum logic [3:0] {
      PH_BEGIN     = 4'd0,
      PH_PREFIX    = 4'd1,
      PH_LEAD      = 4'd2,
      PH_WHOLE     = 4'd3,
      PH_FRAC      = 4'd4,
      PH_COLON_MS  = 4'd5,
      PH_MIN_SEC   = 4'd6,
      PH_COLON_HM  = 4'd7,
      PH_HOUR_MIN  = 4'd8,
      PH_COLON_SEC = 4'd9,
      PH_SEC       = 4'd10,
      PH_END_FIRST = 4'd11
   } phase_e;

   // How the whole seconds of a time are built
   typedef enum int {
      FORM_PLAIN,
      FORM_MIN_SEC,
      FORM_HOUR
   } form_e;

   // Kinds of random request string
   typedef enum int {
      MSG_GOOD,
      MSG_NOISE,
      MSG_MUTATE,
      MSG_TRUNCATE,
      MSG_INSERT
   } msg_kind_e;

   typedef struct packed {
      logic                range_valid;
      logic [SEC_W-1:0]    start_seconds;
      logic [MICROS_W-1:0] start_micros;
      logic                end_present;
      logic [SEC_W-1:0]    end_seconds;
      logic [MICROS_W-1:0] end_micros;
   } range_t;

   typedef struct {
      string  text;
      bit     typed;
      range_t want;
   } vector_t;

   localparam range_t NO_RANGE = '0;
   localparam char_type NPT_PREFIX [4] = '{CH_N, CH_P, CH_T, CH_COLON};
   localparam string GRAMMAR_CHARS = "0123456789:,.npt";

   logic clock;
   logic reset;

   npt_req_if                          req_chan ();
   npt_rsp_if #(.SECONDS_WIDTH(SEC_W)) rsp_chan ();

   npt_time_range_parser #(
      .FRAC_DIGITS   (FRAC_KEEP),
      .SECONDS_WIDTH (SEC_W)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Parser state of the predictor
   phase_e      phase;
   bit          in_end;
   int unsigned pfx_cnt;
   logic [63:0] acc;
   int unsigned acc_digits;
   logic [63:0] grp1;
   logic [63:0] grp2;
   logic [63:0] frac;
   int unsigned frac_digits;
   logic [63:0] start_sec;
   logic [63:0] start_us;
   bit          failed;

   range_t pending_ranges [$];
   int     failures;
   int     items_sent;
   int     cycles;
   bit     no_idle;

   // Directed strings; typed results only where they are obvious
   vector_t directed_tab [23] = '{
      '{"0",          1, '{1'b1, 32'd0, 20'd0, 1'b0, 32'd0, 20'd0}},
      '{"npt:10",     1, '{1'b1, 32'd10, 20'd0, 1'b0, 32'd0, 20'd0}},
      '{"npt:",       1, NO_RANGE},
      '{"nq",         1, NO_RANGE},
      '{",",          1, NO_RANGE},
      '{"5,",         1, NO_RANGE},
      '{",5",         1, '{1'b1, 32'd0, 20'd0, 1'b1, 32'd5, 20'd0}},
      '{"12:34",      0, NO_RANGE},
      '{"123:04:05",  0, NO_RANGE},
      '{"01:02:03",   0, NO_RANGE},
      '{"1:05",       1, NO_RANGE},
      '{"12:3",       1, NO_RANGE},
      '{"5.",         1, '{1'b1, 32'd5, 20'd0, 1'b0, 32'd0, 20'd0}},
      '{"1.1234567",  1, '{1'b1, 32'd1, 20'd123456, 1'b0, 32'd0, 20'd0}},
      '{"4294967295", 1, '{1'b1, 32'hFFFF_FFFF, 20'd0, 1'b0, 32'd0, 20'd0}},
      '{"4294967296", 1, NO_RANGE},
      '{"5,5",        1, NO_RANGE},
      '{"5.5,5.6",    0, NO_RANGE},
      '{"npt:1.5,10:00.25", 0, NO_RANGE},
      '{"9x",         1, NO_RANGE},
      '{"99:99:99.999999,1193046:28:15", 0, NO_RANGE},
      '{"1193046:28:16", 1, NO_RANGE},
      '{"12:34:56:7", 1, NO_RANGE}
   };

   function automatic void parse_clear();
      phase       = PH_BEGIN;
      in_end      = 1'b0;
      pfx_cnt     = 0;
      acc         = '0;
      acc_digits  = 0;
      grp1        = '0;
      grp2        = '0;
      frac        = '0;
      frac_digits = 0;
      start_sec   = '0;
      start_us    = '0;
      failed      = 1'b0;
   endfunction

   // Append one digit, saturating just above the largest second count
   function automatic void digit_push(input int unsigned d);
      logic [63:0] v;
      v   = acc * 64'd10 + d;
      acc = (v > SEC_LIMIT) ? SEC_LIMIT + 64'd1 : v;
      if (acc_digits < 3)
         acc_digits++;
   endfunction

   function automatic bit whole_close(input form_e kind);
      logic [63:0] w;
      case (kind)
         FORM_PLAIN:   w = acc;
         FORM_MIN_SEC: w = grp1 * 64'd60 + acc;
         default:      w = grp1 * 64'd3600 + grp2 * 64'd60 + acc;
      endcase
      if (w > SEC_LIMIT) begin
         failed = 1'b1;
         return 1'b0;
      end
      acc         = w;
      frac        = '0;
      frac_digits = 0;
      return 1'b1;
   endfunction

   // Scale the kept fraction digits to microseconds
   function automatic logic [63:0] frac_scaled();
      logic [63:0] f;
      f = frac;
      for (int i = frac_digits; i < FRAC_KEEP; i++)
         f = f * 64'd10;
      return f;
   endfunction

   // Comma after a time: hold it as the start, or fail on a second comma
   function automatic void start_hold();
      if (in_end) begin
         failed = 1'b1;
         return;
      end
      start_sec = acc;
      start_us  = frac_scaled();
      phase     = PH_END_FIRST;
   endfunction

   function automatic void whole_done(input char_type c, input form_e kind);
      if (!whole_close(kind))
         return;
      if (c == CH_DOT)
         phase = PH_FRAC;
      else
         start_hold();
   endfunction

   function automatic void lead_take(input char_type c, input bit dig, input int unsigned d);
      if (c == CH_COMMA) begin
         start_sec = '0;
         start_us  = '0;
         phase     = PH_END_FIRST;
      end else if (dig) begin
         acc        = d;
         acc_digits = 1;
         phase      = PH_WHOLE;
      end else begin
         failed = 1'b1;
      end
   endfunction

   function automatic void char_take(input char_type c);
      bit          dig;
      bit          term;
      int unsigned d;
      dig  = (c >= CH_ZERO) && (c <= CH_NINE);
      d    = dig ? int'(c - CH_ZERO) : 0;
      term = (c == CH_COMMA) || (c == CH_DOT);
      case (phase)
         PH_BEGIN: begin
            if (c == CH_N) begin
               pfx_cnt = 1;
               phase   = PH_PREFIX;
            end else begin
               lead_take(c, dig, d);
            end
         end
         PH_PREFIX: begin
            if (pfx_cnt < PREFIX_LEN && c == NPT_PREFIX[pfx_cnt]) begin
               pfx_cnt++;
               if (pfx_cnt == PREFIX_LEN)
                  phase = PH_LEAD;
            end else begin
               failed = 1'b1;
            end
         end
         PH_LEAD: lead_take(c, dig, d);
         PH_WHOLE: begin
            if (dig)
               digit_push(d);
            else if (term)
               whole_done(c, FORM_PLAIN);
            else if (c == CH_COLON && acc_digits >= 2) begin
               grp1  = acc;
               phase = (acc_digits > 2) ? PH_COLON_HM : PH_COLON_MS;
            end else
               failed = 1'b1;
         end
         PH_FRAC: begin
            if (dig) begin
               if (frac_digits < FRAC_KEEP) begin
                  frac = frac * 64'd10 + d;
                  frac_digits++;
               end
            end else if (c == CH_COMMA)
               start_hold();
            else
               failed = 1'b1;
         end
         PH_COLON_MS, PH_COLON_HM, PH_COLON_SEC: begin
            if (dig) begin
               acc        = d;
               acc_digits = 1;
               phase      = (phase == PH_COLON_MS) ? PH_MIN_SEC :
                            (phase == PH_COLON_HM) ? PH_HOUR_MIN : PH_SEC;
            end else begin
               failed = 1'b1;
            end
         end
         PH_MIN_SEC, PH_HOUR_MIN, PH_SEC: begin
            if (dig) begin
               if (acc_digits >= 2)
                  failed = 1'b1;
               else
                  digit_push(d);
            end else if (acc_digits != 2)
               failed = 1'b1;
            else if (c == CH_COLON && phase != PH_SEC) begin
               grp2  = acc;
               phase = PH_COLON_SEC;
            end else if (term && phase != PH_HOUR_MIN)
               whole_done(c, (phase == PH_MIN_SEC) ? FORM_MIN_SEC : FORM_HOUR);
            else
               failed = 1'b1;
         end
         PH_END_FIRST: begin
            if (dig) begin
               acc        = d;
               acc_digits = 1;
               phase      = PH_WHOLE;
               in_end     = 1'b1;
            end else begin
               failed = 1'b1;
            end
         end
         default: failed = 1'b1;
      endcase
   endfunction

   // Advance the parser by one request; return 1 with the range on the last character
   function automatic bit range_predict(input char_type c, input bit last, output range_t r);
      logic [63:0] sec;
      logic [63:0] fr;
      r = NO_RANGE;
      if (!failed)
         char_take(c);
      if (!last)
         return 1'b0;
      if (!failed) begin
         if (phase == PH_WHOLE)
            void'(whole_close(FORM_PLAIN));
         else if ((phase == PH_MIN_SEC || phase == PH_SEC) && acc_digits == 2)
            void'(whole_close((phase == PH_MIN_SEC) ? FORM_MIN_SEC : FORM_HOUR));
         else if (phase != PH_FRAC)
            failed = 1'b1;
      end
      if (!failed) begin
         sec = acc;
         fr  = frac_scaled();
         if (!in_end) begin
            r.range_valid   = 1'b1;
            r.start_seconds = sec[SEC_W-1:0];
            r.start_micros  = fr[MICROS_W-1:0];
         end else if (start_sec < sec || (start_sec == sec && start_us < fr)) begin
            r.range_valid   = 1'b1;
            r.start_seconds = start_sec[SEC_W-1:0];
            r.start_micros  = start_us[MICROS_W-1:0];
            r.end_present   = 1'b1;
            r.end_seconds   = sec[SEC_W-1:0];
            r.end_micros    = fr[MICROS_W-1:0];
         end
      end
      parse_clear();
      return 1'b1;
   endfunction

   function automatic int idle_draw();
      return no_idle ? 0 : int'($urandom_range(0, 4));
   endfunction

   function automatic void digits_add(ref char_type q[$], input int n);
      for (int i = 0; i < n; i++)
         q.push_back(CH_ZERO + char_type'($urandom_range(0, 9)));
   endfunction

   // One time value in a random form, optionally with a fraction
   function automatic void time_add(ref char_type q[$]);
      int n;
      case ($urandom_range(0, 2))
         0: begin
            n = ($urandom_range(0, 5) == 0) ? int'($urandom_range(4, 11))
                                            : int'($urandom_range(1, 3));
            digits_add(q, n);
         end
         1: begin
            digits_add(q, 2);
            q.push_back(CH_COLON);
            digits_add(q, 2);
         end
         default: begin
            n = ($urandom_range(0, 5) == 0) ? int'($urandom_range(4, 7))
                                            : int'($urandom_range(2, 3));
            digits_add(q, n);
            q.push_back(CH_COLON);
            digits_add(q, 2);
            q.push_back(CH_COLON);
            digits_add(q, 2);
         end
      endcase
      if ($urandom_range(0, 1) == 1) begin
         q.push_back(CH_DOT);
         digits_add(q, $urandom_range(0, 8));
      end
   endfunction

   // A well-formed range string: optional prefix, start, end or both
   function automatic void range_msg_build(ref char_type q[$]);
      q.delete();
      if ($urandom_range(0, 1) == 1)
         foreach (NPT_PREFIX[i])
            q.push_back(NPT_PREFIX[i]);
      case ($urandom_range(0, 3))
         0: time_add(q);
         1: begin
            q.push_back(CH_COMMA);
            time_add(q);
         end
         default: begin
            time_add(q);
            q.push_back(CH_COMMA);
            time_add(q);
         end
      endcase
   endfunction

   function automatic char_type byte_draw();
      if ($urandom_range(0, 1) == 1)
         return char_type'(GRAMMAR_CHARS[$urandom_range(0, GRAMMAR_CHARS.len() - 1)]);
      return char_type'($urandom_range(0, 255));
   endfunction

   // Send one string; entered and left at a falling edge
   task automatic message_send(ref char_type text[$], input bit use_want, input range_t want);
      int     gap;
      bit     last;
      range_t pred;
      foreach (text[i]) begin
         gap  = idle_draw();
         last = (i == text.size() - 1);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_chan.valid     <= 1'b1;
         req_chan.char_code <= text[i];
         req_chan.last_char <= last;
         @(posedge clock);
         while (!req_chan.ready)
            @(posedge clock);
         if (range_predict(text[i], last, pred))
            pending_ranges.push_back(use_want ? want : pred);
         items_sent++;
         @(negedge clock);
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("npt_time_range_parser regression: fail");
         $finish;
      end
   end

   // Result side: hold ready low for a random stall before each result
   initial begin : result_sink
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready))
            @(posedge clock);
         @(negedge clock);
      end
   end

   // Compare each result with the oldest expected range
   always @(posedge clock) begin : range_check
      range_t want;
      bit     bad;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_ranges.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("unexpected result: valid=%0b start=%0d.%0d end=%0b %0d.%0d",
                        rsp_chan.range_valid, rsp_chan.start_seconds,
                        rsp_chan.start_micros, rsp_chan.end_present,
                        rsp_chan.end_seconds, rsp_chan.end_micros);
         end else begin
            want = pending_ranges.pop_front();
            bad  = 1'b0;
            if (rsp_chan.range_valid   !== want.range_valid)   bad = 1'b1;
            if (rsp_chan.start_seconds !== want.start_seconds) bad = 1'b1;
            if (rsp_chan.start_micros  !== want.start_micros)  bad = 1'b1;
            if (rsp_chan.end_present   !== want.end_present)   bad = 1'b1;
            if (rsp_chan.end_seconds   !== want.end_seconds)   bad = 1'b1;
            if (rsp_chan.end_micros    !== want.end_micros)    bad = 1'b1;
            if (bad) begin
               failures++;
               if (failures <= REPORT_MAX)
                  $display({"range mismatch: expected valid=%0b start=%0d.%0d end=%0b %0d.%0d,",
                            " got valid=%0b start=%0d.%0d end=%0b %0d.%0d"},
                           want.range_valid, want.start_seconds, want.start_micros,
                           want.end_present, want.end_seconds, want.end_micros,
                           rsp_chan.range_valid, rsp_chan.start_seconds,
                           rsp_chan.start_micros, rsp_chan.end_present,
                           rsp_chan.end_seconds, rsp_chan.end_micros);
            end
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      char_type  text [$];
      msg_kind_e kind;
      int        pos;
      int        msg_idx;
      int        random_base;
      int        cut;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = '0;
      req_chan.last_char = 1'b0;
      failures           = 0;
      items_sent         = 0;
      cycles             = 0;
      no_idle            = 1'b0;
      parse_clear();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed strings
      foreach (directed_tab[r]) begin
         text.delete();
         for (int i = 0; i < directed_tab[r].text.len(); i++)
            text.push_back(char_type'(directed_tab[r].text[i]));
         message_send(text, directed_tab[r].typed, directed_tab[r].want);
      end

      // Random strings, mostly well formed
      random_base = items_sent;
      msg_idx     = 0;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0)
            no_idle = ~no_idle;

         // Drain every pending result before going on
         if (msg_idx == 40 || $urandom_range(0, 63) == 0) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
            while (pending_ranges.size() != 0)
               @(negedge clock);
         end

         case ($urandom_range(0, 11))
            0, 1:    kind = MSG_NOISE;
            2:       kind = MSG_MUTATE;
            3:       kind = MSG_TRUNCATE;
            4:       kind = MSG_INSERT;
            default: kind = MSG_GOOD;
         endcase

         if (kind == MSG_NOISE) begin
            text.delete();
            repeat ($urandom_range(1, 10))
               text.push_back(byte_draw());
         end else begin
            range_msg_build(text);
            pos = $urandom_range(0, text.size() - 1);
            case (kind)
               MSG_MUTATE: text[pos] = byte_draw();
               MSG_INSERT: text.insert(pos, byte_draw());
               MSG_TRUNCATE: begin
                  cut = $urandom_range(0, text.size() - 1);
                  while (text.size() > 1 && cut > 0) begin
                     void'(text.pop_back());
                     cut--;
                  end
               end
               default: ;
            endcase
         end
         message_send(text, 1'b0, NO_RANGE);
         msg_idx++;
      end

      // Drop valid and let the last results drain
      req_chan.valid <= 1'b0;
      while (pending_ranges.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_ranges.size() != 0)
         failures++;

      if (failures == 0)
         $display("npt_time_range_parser regression: pass");
      else
         $display("npt_time_range_parser regression: fail");
      $finish;
   end

endmodule
